/* design/utf8_to_custom_codepage_unit_macros.svh */
// Assertion macros for the UTF-8 to codepage unit.
// Uses the unit's clock and reset names; no other dependencies.
`ifndef UTF8_TO_CUSTOM_CODEPAGE_UNIT_MACROS_SVH
`define UTF8_TO_CUSTOM_CODEPAGE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define UCU_ASSERT_IMP(name, cond, prop) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("assertion failed");
`define UCU_ASSERT_NEXT(name, cond, prop) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("assertion failed");
`else
`define UCU_ASSERT_IMP(name, cond, prop)
`define UCU_ASSERT_NEXT(name, cond, prop)
`endif

`endif

/* design/utf8cp_pkg.sv */
// Package for the UTF-8 to codepage unit: display codes, letter table,
// lead byte decode and sequence lookup. No dependencies.
`default_nettype none

package utf8cp_pkg;

   localparam int unsigned LETTER_COUNT = 22;

   localparam logic [7:0] CODE_LETTER_BASE = 8'h80;
   localparam logic [7:0] CODE_UNKNOWN     = 8'h96;
   localparam logic [7:0] CODE_SPACE       = 8'h20;
   localparam logic [7:0] CODE_TAB         = 8'h09;
   localparam logic [7:0] CODE_NEWLINE     = 8'h0A;
   localparam logic [7:0] CODE_PRINT_LO    = 8'h20;
   localparam logic [7:0] CODE_PRINT_HI    = 8'h7E;

   typedef logic [15:0] letter_type;

   localparam letter_type LETTER_TABLE [LETTER_COUNT] = '{
      16'hC480, 16'hC48C, 16'hC492, 16'hC4A2, 16'hC4AA, 16'hC4B6, 16'hC4BB, 16'hC585,
      16'hC5A0, 16'hC5AA, 16'hC5BD, 16'hC481, 16'hC48D, 16'hC493, 16'hC4A3, 16'hC4AB,
      16'hC4B7, 16'hC4BC, 16'hC586, 16'hC5A1, 16'hC5AB, 16'hC5BE
   };

   // 0 = stray byte, else total sequence length
   function automatic logic [2:0] lead_length(input logic [7:0] c);
      logic [2:0] len;
      if (c[7] == 1'b0) begin
         len = 3'd1;
      end else if (c[7:5] == 3'b110) begin
         len = 3'd2;
      end else if (c[7:4] == 4'b1110) begin
         len = 3'd3;
      end else if (c[7:3] == 5'b11110) begin
         len = 3'd4;
      end else begin
         len = 3'd0;
      end
      return len;
   endfunction

   // full sequence, lead byte in bits 31:24
   function automatic logic [7:0] map_code(input logic [31:0] full);
      logic [7:0] code;
      code = CODE_UNKNOWN;
      for (int k = 0; k < LETTER_COUNT; k++) begin
         if (full == {LETTER_TABLE[k], 16'h0000}) begin
            code = CODE_LETTER_BASE + 8'(k);
         end
      end
      return code;
   endfunction

endpackage

`default_nettype wire

/* design/utf8_to_custom_codepage_unit.sv */
// UTF-8 to single-byte display code unit, top level.
// Depends on utf8cp_pkg and utf8_to_custom_codepage_unit_macros.svh.
//
//  channel | dir | tdata        | tuser       | tlast
//  req     | in  | [7:0] byte   | -           | last byte of string
//  rsp     | out | [7:0] code   | [0] char ok | end of string
//
// One byte per cycle unless an rsp stall holds it; a req beat passes the input
// register, then decode and state update into the result register.
// A byte that leaves a sequence open gives no rsp beat unless it ends the string.
// Reset clears both stages and the sequence state.
// rsp stalls hold the result register; req is taken when the input register is
// empty, the result register is free, or the byte in flight gives no beat.
`default_nettype none
`include "utf8_to_custom_codepage_unit_macros.svh"

module utf8_to_custom_codepage_unit
   import utf8cp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_byte
   input  wire logic       req_tlast,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_char
   output logic            rsp_tuser,   // [0] char_valid
   output logic            rsp_tlast
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;

   logic [1:0]  pending_ff, pending_in;
   logic [23:0] code_ff, code_in;
   logic [2:0]  len_ff, len_in;

   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_char_ff, out_char_in;
   logic        out_ok_ff, out_ok_in;
   logic        out_last_ff, out_last_in;

   logic        have_char;
   logic [7:0]  ch;
   logic [1:0]  pos;
   logic [2:0]  pos_wide;
   logic [2:0]  lead_len;
   logic [1:0]  pending_dec;
   logic [31:0] full;
   logic        has_result;
   logic        out_free;
   logic        process;
   logic        load_out;
   logic        printable;

   always_comb begin
      pos_wide    = len_ff - {1'b0, pending_ff};
      pos         = (pos_wide[1:0] == 2'd0) ? 2'd1 : pos_wide[1:0];
      pending_dec = pending_ff - 2'd1;
      lead_len    = lead_length(in_byte_ff);
      printable   = (in_byte_ff >= CODE_PRINT_LO && in_byte_ff <= CODE_PRINT_HI)
                    || in_byte_ff == CODE_NEWLINE;
      full        = {code_ff, 8'h00};
      have_char   = 1'b0;
      ch          = 8'h00;
      pending_in  = pending_ff;
      code_in     = code_ff;
      len_in      = len_ff;

      if (pending_ff != 2'd0) begin
         pending_in = pending_dec;
         if (pending_dec == 2'd0) begin
            case (pos)
               2'd1:    full = full | {8'h00, in_byte_ff, 16'h0000};
               2'd2:    full = full | {16'h0000, in_byte_ff, 8'h00};
               default: full = full | {24'h000000, in_byte_ff};
            endcase
            ch        = map_code(full);
            have_char = 1'b1;
            code_in   = '0;
            len_in    = '0;
         end else begin
            case (pos)
               2'd1:    code_in = code_ff | {8'h00, in_byte_ff, 8'h00};
               default: code_in = code_ff | {16'h0000, in_byte_ff};
            endcase
         end
      end else if (printable) begin
         ch        = in_byte_ff;
         have_char = 1'b1;
      end else if (in_byte_ff == CODE_TAB) begin
         ch        = CODE_SPACE;
         have_char = 1'b1;
      end else if (lead_len <= 3'd1) begin
         ch        = CODE_UNKNOWN;
         have_char = 1'b1;
      end else begin
         len_in     = lead_len;
         pending_in = 2'(lead_len - 3'd1);
         code_in    = {in_byte_ff, 16'h0000};
      end

      if (in_last_ff) begin
         pending_in = '0;
         code_in    = '0;
         len_in     = '0;
      end

      has_result  = have_char || in_last_ff;
      out_free    = !out_valid_ff || rsp_tready;
      process     = in_valid_ff && (out_free || !has_result);
      load_out    = process && has_result;
      req_tready  = !in_valid_ff || process;
      in_valid_in = req_tvalid ? 1'b1 : (in_valid_ff && !process);

      out_valid_in = load_out ? 1'b1 : (out_valid_ff && !rsp_tready);
      out_char_in  = load_out ? ch : out_char_ff;
      out_ok_in    = load_out ? have_char : out_ok_ff;
      out_last_in  = load_out ? in_last_ff : out_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pending_ff   <= '0;
         code_ff      <= '0;
         len_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (process) begin
            pending_ff <= pending_in;
            code_ff    <= code_in;
            len_ff     <= len_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      out_char_ff <= out_char_in;
      out_ok_ff   <= out_ok_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tuser  = out_ok_ff;
   assign rsp_tlast  = out_last_ff;

   `UCU_ASSERT_IMP(a_empty_beat_ends, rsp_tvalid && !rsp_tuser, rsp_tlast)
   `UCU_ASSERT_IMP(a_empty_beat_zero, rsp_tvalid && !rsp_tuser, rsp_tdata == 8'h00)
   `UCU_ASSERT_NEXT(a_last_clears, process && in_last_ff,
                    pending_ff == 2'd0 && code_ff == 24'h0 && len_ff == 3'd0)
   `UCU_ASSERT_IMP(a_pending_sane, pending_ff != 2'd0,
                   len_ff >= 3'd2 && {1'b0, pending_ff} < len_ff)

endmodule

`default_nettype wire
